/* sv/first_fit_chunk_allocator_assert.svh */
// Assertion macros for the chunk allocator
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT_IMPLIES(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define FFCA_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FFCA_ASSERT_IMPLIES(label, clk, rstn, a, c)
`define FFCA_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

/* sv/ffca_pkg.sv */
// -----------------------------------------------------------------------------
// ffca_pkg: shared types and constants of the first-fit chunk allocator
// Table geometry, status codes, sequencer states and the entry layout.
// -----------------------------------------------------------------------------
package ffca_pkg;
    localparam int HEAP_BYTES    = 65536;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OFF_W = 16;
    localparam int LEN_W = 17;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADFREE = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             used;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRD,      // coalesce: read entry i
        S_CRD2,     // coalesce: read entry i+1
        S_CCHK,     // coalesce: compare pair
        S_SHRD,     // shift: read source
        S_SHWR,     // shift: write destination
        S_FRD,      // fit / free scan read
        S_FCHK,     // fit / free check
        S_DONE
    } state_t;

    // Memory port request
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;
endpackage

/* sv/ffca_table.sv */
// -----------------------------------------------------------------------------
// ffca_table: chunk table memory
// One write and one read port, registered read data.
// -----------------------------------------------------------------------------
module ffca_table import ffca_pkg::*; (
    input  logic     aclk,
    input  mem_req_t req,
    output entry_t   rd_data
);
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* sv/ffca_seq.sv */
// -----------------------------------------------------------------------------
// ffca_seq: request sequencer
// Walks the table for coalescing, first-fit search, insert and free lookup.
// -----------------------------------------------------------------------------
module ffca_seq import ffca_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             op,
    input  logic [LEN_W-1:0] size,
    input  logic [OFF_W-1:0] where,
    input  entry_t           rd_data,
    output mem_req_t         req,
    output logic             busy,
    output logic             done,
    output logic [OFF_W-1:0] res_offset,
    output logic [2:0]       res_status,
    output logic [CNT_W-1:0] count
);
    // scan phases
    typedef enum logic [1:0] {PH_COAL, PH_DROP, PH_INS, PH_NONE} phase_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] k_reg, k_next;
    phase_t           ph_reg, ph_next;
    entry_t           a_reg, a_next;      // entry i held during coalesce
    entry_t           ins_reg, ins_next;  // entry to insert after shift
    entry_t           mv_reg, mv_next;    // entry being moved
    logic             init_reg, init_next; // entry 0 not yet written since reset
    logic             op_reg;
    logic [LEN_W-1:0] size_reg;
    logic [OFF_W-1:0] where_reg;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [2:0]       st_reg, st_next;
    entry_t           rd_eff;
    logic             req_addr_was0;
    logic [LEN_W-1:0] tail;
    logic             pair_free;      // entries i and i+1 both free
    logic             fits;           // entry free and long enough
    logic             split_blocked;  // split needed but table full
    logic             free_hit;       // entry starts at the freed offset

    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);
    localparam entry_t ENTRY0 = '{start: '0, length: LEN_W'(HEAP_BYTES), used: 1'b0};

    // entry 0 reads as its reset value until first written
    always_comb begin
        rd_eff = rd_data;
        if (init_reg && req_addr_was0) rd_eff = ENTRY0;
    end

    always_ff @(posedge aclk) begin
        req_addr_was0 <= (req.rd_addr == '0);
    end

    // entry checks on the data just read
    assign tail          = rd_eff.length - size_reg;
    assign pair_free     = !a_reg.used && !rd_eff.used;
    assign fits          = !rd_eff.used && (rd_eff.length >= size_reg);
    assign split_blocked = (tail != '0) && (count_reg >= FULL);
    assign free_hit      = (rd_eff.start == where_reg);

    // request capture
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg    <= op;
            size_reg  <= size;
            where_reg <= where;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= ONE;
            init_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            init_reg  <= init_next;
        end
        i_reg   <= i_next;
        k_reg   <= k_next;
        ph_reg  <= ph_next;
        a_reg   <= a_next;
        ins_reg <= ins_next;
        mv_reg  <= mv_next;
        off_reg <= off_next;
        st_reg  <= st_next;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        init_next  = init_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        a_next     = a_reg;
        ins_next   = ins_reg;
        mv_next    = mv_reg;
        off_next   = off_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    i_next   = '0;
                    off_next = '0;
                    if (op == OP_FREE) begin
                        st_next    = ST_BADFREE;
                        state_next = S_FRD;
                    end else if (size == '0) begin
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end else begin
                        st_next    = ST_NOFIT;
                        state_next = S_CRD;
                    end
                end
            end
            S_CRD: begin
                if (i_reg + ONE >= count_reg) begin
                    i_next     = '0;
                    state_next = S_FRD;
                end else begin
                    state_next = S_CRD2;
                end
            end
            S_CRD2: begin
                a_next     = rd_eff;
                state_next = S_CCHK;
            end
            S_CCHK: begin
                if (pair_free) begin
                    // merge i+1 into i, then drop i+1
                    if (i_reg == '0) init_next = 1'b0;
                    ph_next    = PH_DROP;
                    k_next     = i_reg + ONE;
                    state_next = S_SHRD;
                end else begin
                    i_next     = i_reg + ONE;
                    state_next = S_CRD;
                end
            end
            S_SHRD: begin
                if (ph_reg == PH_DROP) begin
                    if (k_reg + ONE >= count_reg) begin
                        count_next = count_reg - ONE;
                        state_next = S_CRD;
                    end else begin
                        state_next = S_SHWR;
                    end
                end else begin
                    if (k_reg <= i_reg + ONE) begin
                        count_next = count_reg + ONE;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SHWR;
                    end
                end
            end
            S_SHWR: begin
                if (ph_reg == PH_DROP) k_next = k_reg + ONE;
                else k_next = k_reg - ONE;
                state_next = S_SHRD;
            end
            S_FRD: begin
                if (i_reg >= count_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                state_next = S_FRD;
                i_next     = i_reg + ONE;
                if (op_reg == OP_FREE) begin
                    if (free_hit) begin
                        if (rd_eff.used) begin
                            if (i_reg == '0) init_next = 1'b0;
                            st_next = ST_OK;
                        end
                        state_next = S_DONE;
                    end
                end else if (fits) begin
                    if (split_blocked) begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        if (i_reg == '0) init_next = 1'b0;
                        off_next = rd_eff.start;
                        st_next  = ST_OK;
                        i_next   = i_reg;
                        if (tail != '0) begin
                            ins_next.start  = rd_eff.start + size_reg[OFF_W-1:0];
                            ins_next.length = tail;
                            ins_next.used   = 1'b0;
                            ph_next    = PH_INS;
                            k_next     = count_reg;
                            state_next = S_SHRD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // table memory requests
    always_comb begin
        req = '0;
        unique case (state_reg)
            S_CRD: begin
                if (i_reg + ONE < count_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = i_reg[IDX_W-1:0];
                end
            end
            S_CRD2: begin
                req.rd_en   = 1'b1;
                req.rd_addr = IDX_W'(i_reg + ONE);
            end
            S_CCHK: begin
                if (pair_free) begin
                    req.wr_en          = 1'b1;
                    req.wr_addr        = i_reg[IDX_W-1:0];
                    req.wr_data        = a_reg;
                    req.wr_data.length = a_reg.length + rd_eff.length;
                end
            end
            S_SHRD: begin
                if (ph_reg == PH_DROP) begin
                    if (k_reg + ONE < count_reg) begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = IDX_W'(k_reg + ONE);
                    end
                end else begin
                    if (k_reg <= i_reg + ONE) begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = IDX_W'(i_reg + ONE);
                        req.wr_data = ins_reg;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = IDX_W'(k_reg - ONE);
                    end
                end
            end
            S_SHWR: begin
                req.wr_en   = 1'b1;
                req.wr_data = rd_eff;
                req.wr_addr = k_reg[IDX_W-1:0];
            end
            S_FRD: begin
                if (i_reg < count_reg) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = i_reg[IDX_W-1:0];
                end
            end
            S_FCHK: begin
                if (op_reg == OP_FREE) begin
                    if (free_hit && rd_eff.used) begin
                        req.wr_en        = 1'b1;
                        req.wr_addr      = i_reg[IDX_W-1:0];
                        req.wr_data      = rd_eff;
                        req.wr_data.used = 1'b0;
                    end
                end else if (fits && !split_blocked) begin
                    req.wr_en          = 1'b1;
                    req.wr_addr        = i_reg[IDX_W-1:0];
                    req.wr_data.start  = rd_eff.start;
                    req.wr_data.length = size_reg;
                    req.wr_data.used   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res_offset = (st_reg == ST_OK) ? off_reg : '0;
    assign res_status = st_reg;
    assign count      = count_reg;
endmodule

/* sv/first_fit_chunk_allocator.sv */
// -----------------------------------------------------------------------------
// first_fit_chunk_allocator: first-fit heap allocator over a chunk table
// An alloc request merges adjacent free chunks, comparing each pair of entries,
// then scans for the first fit; a free request only scans for the freed offset.
// Entries are moved on a merge or split and are read through the registered
// table memory; the worst case is a full table of free chunks merged into one.
// One request is worked on at a time, and the next request is taken once the
// result item in the output register has been accepted.
// -----------------------------------------------------------------------------
`include "first_fit_chunk_allocator_assert.svh"
module first_fit_chunk_allocator import ffca_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[0], req_size[17:1], free_offset[33:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // block_offset[15:0], status[18:16]
);
    mem_req_t         req;
    entry_t           rd_data;
    logic             busy, done;
    logic [OFF_W-1:0] res_offset;
    logic [2:0]       res_status;
    logic [CNT_W-1:0] count;
    logic             m_valid_reg;
    logic [23:0]      m_data_reg;
    logic             start;
    logic             count_in_range;

    assign s_tready = !busy && !m_valid_reg;
    assign start    = s_tvalid && s_tready;

    ffca_table u_table (.aclk(aclk), .req(req), .rd_data(rd_data));

    ffca_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .op(s_tdata[0]), .size(s_tdata[17:1]), .where(s_tdata[33:18]),
        .rd_data(rd_data), .req(req), .busy(busy), .done(done),
        .res_offset(res_offset), .res_status(res_status), .count(count)
    );

    // output register; the next request waits until this item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) m_data_reg <= {5'd0, res_status, res_offset};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign count_in_range = (count >= CNT_W'(1)) && (count <= CNT_W'(TABLE_ENTRIES));

    `FFCA_ASSERT_IMPLIES(a_count_range, aclk, aresetn, 1'b1, count_in_range)
    `FFCA_ASSERT_IMPLIES(a_no_start_busy, aclk, aresetn, busy, !start)
    `FFCA_ASSERT_NEXT(a_done_valid, aclk, aresetn, done, m_tvalid)
endmodule

/* dv/first_fit_chunk_allocator_tb.sv */
// -----------------------------------------------------------------------------
// first_fit_chunk_allocator_tb: self-checking bench for the chunk allocator
// Streams alloc and free requests with random gaps and back-pressure, keeps
// its own copy of the chunk table to predict each status and offset, and
// compares every result item with the oldest prediction.
// -----------------------------------------------------------------------------
module first_fit_chunk_allocator_tb;
    import ffca_pkg::*;

    typedef struct packed {
        logic [15:0] offset;
        logic [2:0]  status;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    first_fit_chunk_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Mirror of the chunk table
    logic [15:0] tbl_start [TABLE_ENTRIES];
    logic [16:0] tbl_len   [TABLE_ENTRIES];
    logic        tbl_used  [TABLE_ENTRIES];
    int          tbl_count;

    logic [39:0]   pending_reqs[$];
    alloc_result_t expected_results[$];
    int            errors;
    bit            no_idle;
    bit            hold_send;
    int            send_gap;
    int            recv_gap;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void table_reset();
        tbl_start[0] = 0;
        tbl_len[0]   = 17'(HEAP_BYTES);
        tbl_used[0]  = 1'b0;
        tbl_count    = 1;
    endfunction

    function automatic void remove_at(int pos);
        for (int k = pos; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_len[k]   = tbl_len[k+1];
            tbl_used[k]  = tbl_used[k+1];
        end
        tbl_count--;
    endfunction

    function automatic void insert_free_at(int pos, logic [15:0] st, logic [16:0] ln);
        for (int k = tbl_count; k > pos; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_len[k]   = tbl_len[k-1];
            tbl_used[k]  = tbl_used[k-1];
        end
        tbl_start[pos] = st;
        tbl_len[pos]   = ln;
        tbl_used[pos]  = 1'b0;
        tbl_count++;
    endfunction

    // Predict one request and update the table mirror
    function automatic alloc_result_t predict_request(logic [39:0] req);
        alloc_result_t r;
        logic        op;
        logic [16:0] sz;
        logic [15:0] where;
        logic [16:0] tail;
        int          i;
        op = req[0];
        sz = req[17:1];
        where = req[33:18];
        r.offset = '0;
        if (op == OP_ALLOC) begin
            r.status = ST_NOFIT;
            if (sz == 0) begin
                r.status = ST_ZERO;
            end else begin
                i = 0;
                while (i + 1 < tbl_count) begin
                    if (!tbl_used[i] && !tbl_used[i+1]) begin
                        tbl_len[i] = tbl_len[i] + tbl_len[i+1];
                        remove_at(i + 1);
                    end else begin
                        i++;
                    end
                end
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_used[i] || tbl_len[i] < sz) continue;
                    tail = tbl_len[i] - sz;
                    if (tail != 0 && tbl_count >= TABLE_ENTRIES) begin
                        r.status = ST_FULL;
                        break;
                    end
                    tbl_used[i] = 1'b1;
                    tbl_len[i]  = sz;
                    if (tail != 0) insert_free_at(i + 1, tbl_start[i] + sz[15:0], tail);
                    r.offset = tbl_start[i];
                    r.status = ST_OK;
                    break;
                end
            end
        end else begin
            r.status = ST_BADFREE;
            for (i = 0; i < tbl_count; i++) begin
                if (tbl_start[i] == where) begin
                    if (tbl_used[i]) begin
                        tbl_used[i] = 1'b0;
                        r.status = ST_OK;
                    end
                    break;
                end
            end
        end
        if (r.status != ST_OK) r.offset = '0;
        return r;
    endfunction

    function automatic logic [39:0] pack_req(logic op, logic [16:0] sz, logic [15:0] off);
        return {6'b0, off, sz, op};
    endfunction

    // Driver: predicts at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_request(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_reqs.size() != 0 && !hold_send) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_reqs.pop_front();
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 10);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    alloc_result_t w;
                    w = expected_results.pop_front();
                    if (m_tdata[18:16] != w.status)
                        report_mismatch("status", m_tdata[18:16], w.status);
                    if (m_tdata[15:0] != w.offset)
                        report_mismatch("block_offset", m_tdata[15:0], w.offset);
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 10);
            end
        end
    end

    // Offsets of live blocks are unknown when queuing, so guess from the
    // mirror: refresh candidates from the table when building each phase.
    task automatic queue_phase(int n);
        logic [16:0] sz;
        int          sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                if ($urandom_range(0, 15) == 0) sz = $urandom_range(0, 131071);
                else if ($urandom_range(0, 3) == 0) sz = $urandom_range(1, 8192);
                else sz = $urandom_range(1, 1024);
                pending_reqs.push_back(pack_req(OP_ALLOC, sz, 16'($urandom)));
            end else if (sel < 92 && tbl_count > 0) begin
                // table mirror reflects state at phase start; stale picks give bad frees
                pending_reqs.push_back(pack_req(OP_FREE, 17'($urandom),
                    tbl_start[$urandom_range(0, tbl_count - 1)]));
            end else begin
                pending_reqs.push_back(pack_req(OP_FREE, 17'($urandom), 16'($urandom)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        errors    = 0;
        no_idle   = 1'b0;
        hold_send = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        send_gap  = 0;
        recv_gap  = 0;
        table_reset();
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero size, too big, whole heap, bad frees, exact fit
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd0, 16'hFFFF));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'h1FFFF, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd65537, 16'h0));
        pending_reqs.push_back(pack_req(OP_FREE, 17'h1FFFF, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd65536, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd1, 16'h0));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'h0));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd1, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd65535, 16'h0));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'd1));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'hFFFF));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'd0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd16, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd32768, 16'h0));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'd1));
        pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'd16));
        wait_drained();

        // Table full: small allocs fill the table until a split is refused
        for (int k = 0; k < 63; k++)
            pending_reqs.push_back(pack_req(OP_ALLOC, 17'd4, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd4, 16'h0));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd65536 - 17'd64 * 17'd4, 16'h0));
        for (int k = 0; k < 64; k += 2)
            pending_reqs.push_back(pack_req(OP_FREE, 17'd0, 16'(k * 4)));
        pending_reqs.push_back(pack_req(OP_ALLOC, 17'd100000, 16'h0));
        wait_drained();

        // Random phases, each drained before the next; the sender is held off at the start of phase 5
        for (int p = 0; p < 18; p++) begin
            if (p == 16) no_idle = 1'b1;
            queue_phase(100);
            hold_send = (p == 5);
            if (hold_send) begin
                repeat (50) @(posedge aclk);
                hold_send = 1'b0;
            end
            wait_drained();
        end
        repeat (500) @(posedge aclk);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("first_fit_chunk_allocator test passed");
        end else begin
            $display("first_fit_chunk_allocator test failed");
        end
        $finish;
    end

    initial begin
        #400000000;
        $display("first_fit_chunk_allocator test failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/ffca_pkg.sv
sv/ffca_table.sv
sv/ffca_seq.sv
sv/first_fit_chunk_allocator.sv
dv/first_fit_chunk_allocator_tb.sv
